/* rtl/url_pd_pkg.sv */
// types, constants and hex helpers shared by the url percent decoder
`default_nettype none

package url_pd_pkg;

   localparam logic [7:0] PCT_CHAR = 8'h25;
   localparam int unsigned MAX_RESULTS = 3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       decoded_end;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_PCT   = 3'b010,
      PH_DIGIT = 3'b100
   } phase_type;

   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [1:0]                  cnt;
      logic                        last_end;
   } group_type;

   function automatic logic is_hex(input logic [7:0] b);
      is_hex = (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] b);
      logic [7:0] v;
      v = 8'h00;
      if (b inside {[8'h30:8'h39]}) begin
         v = b - 8'h30;
      end else if (b inside {[8'h61:8'h66]}) begin
         v = b - 8'h61 + 8'd10;
      end else if (b inside {[8'h41:8'h46]}) begin
         v = b - 8'h41 + 8'd10;
      end
      hex_value = v[3:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/url_pd_decode.sv */
// next-state and result group logic for one input byte
`default_nettype none

module url_pd_decode
   import url_pd_pkg::*;
(
   input  phase_type  phase,
   input  logic [7:0] held_digit,
   input  req_type    req,
   output phase_type  phase_next,
   output logic [7:0] held_next,
   output group_type  grp
);

   logic [7:0] b;
   logic       e;
   logic       hx;
   logic       do_fresh;
   logic [1:0] pre_cnt;

   always_comb begin
      b          = req.in_byte;
      e          = req.string_end;
      hx         = is_hex(b);
      do_fresh   = 1'b0;
      pre_cnt    = 2'd0;
      phase_next = PH_IDLE;
      held_next  = held_digit;
      grp        = '0;
      grp.last_end = e;
      case (phase)
         PH_PCT: begin
            if (hx) begin
               if (e) begin
                  grp.bytes[0] = PCT_CHAR;
                  grp.bytes[1] = b;
                  grp.cnt      = 2'd2;
               end else begin
                  held_next  = b;
                  phase_next = PH_DIGIT;
               end
            end else begin
               grp.bytes[0] = PCT_CHAR;
               pre_cnt      = 2'd1;
               do_fresh     = 1'b1;
            end
         end
         PH_DIGIT: begin
            if (hx) begin
               grp.bytes[0] = {hex_value(held_digit), hex_value(b)};
               grp.cnt      = 2'd1;
            end else begin
               grp.bytes[0] = PCT_CHAR;
               grp.bytes[1] = held_digit;
               pre_cnt      = 2'd2;
               do_fresh     = 1'b1;
            end
         end
         default: begin
            do_fresh = 1'b1;
         end
      endcase
      if (do_fresh) begin
         if (b == PCT_CHAR && !e) begin
            phase_next = PH_PCT;
            grp.cnt    = pre_cnt;
         end else begin
            grp.bytes[pre_cnt] = b;
            grp.cnt            = pre_cnt + 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/url_percent_decoder_top.sv */
// top level of the url percent decoder: state, result group buffer, handshakes
//
//   channel | direction | ports                          | payload
//   request | in        | req_valid, req_stall, req_data | req_type (in_byte, string_end)
//   result  | out       | rsp_valid, rsp_stall, rsp_data | rsp_type (out_byte, run_last,
//           |           |                                |   decoded_end)
//
// one input byte per cycle while req_stall is low; an input causing n results (0 to 3)
// occupies the result buffer until its n results have transferred
// a new byte is taken in the cycle the last buffered result transfers
// the first result of an input is valid in the cycle after the input transfer
// synchronous reset clears phase, held digit and the result count and pointer
// rsp_stall holds the current result and back-pressures req_stall
`default_nettype none

module url_percent_decoder_top
   import url_pd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   phase_type  phase_ff, phase_in, phase_dec;
   logic [7:0] held_ff, held_in, held_dec;
   group_type  grp_ff, grp_in, grp_dec;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] ptr_ff, ptr_in;
   logic       req_xfer;
   logic       rsp_xfer;
   logic       at_last;

   url_pd_decode u_decode (
      .phase      (phase_ff),
      .held_digit (held_ff),
      .req        (req_data),
      .phase_next (phase_dec),
      .held_next  (held_dec),
      .grp        (grp_dec)
   );

   assign rsp_valid = (cnt_ff != 2'd0);
   assign at_last   = (ptr_ff == cnt_ff - 2'd1);
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign req_stall = !(cnt_ff == 2'd0 || (rsp_xfer && at_last));
   assign req_xfer  = req_valid && !req_stall;

   assign rsp_data.out_byte    = grp_ff.bytes[ptr_ff];
   assign rsp_data.run_last    = at_last;
   assign rsp_data.decoded_end = at_last && grp_ff.last_end;

   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      grp_in   = grp_ff;
      cnt_in   = cnt_ff;
      ptr_in   = ptr_ff;
      if (rsp_xfer) begin
         if (at_last) begin
            cnt_in = 2'd0;
            ptr_in = 2'd0;
         end else begin
            ptr_in = ptr_ff + 2'd1;
         end
      end
      if (req_xfer) begin
         phase_in = phase_dec;
         held_in  = held_dec;
         grp_in   = grp_dec;
         cnt_in   = grp_dec.cnt;
         ptr_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= 8'h00;
         cnt_ff   <= 2'd0;
         ptr_ff   <= 2'd0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         cnt_ff   <= cnt_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

`ifndef SYNTH
   // a new transfer only lands once the buffered group has drained or its last result transfers
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> (cnt_ff == 2'd0 || (rsp_xfer && at_last)))
      else $error("request transfer while results still buffered");

   // read pointer stays inside the buffered group
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 2'd0) |-> (ptr_ff < cnt_ff))
      else $error("result pointer beyond group");

   // a held first digit is always a hex digit
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DIGIT) |-> is_hex(held_ff))
      else $error("held digit is not hex");

   // nothing stays held after the final byte of a string
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_data.string_end) |=> (phase_ff == PH_IDLE))
      else $error("bytes held after string end");
`endif

endmodule

`default_nettype wire

/* bench/tb_url_percent_decoder_top.sv */
// self-checking testbench for the url percent decoder: directed strings, random streams, idling
`timescale 1ns / 100ps

module tb_url_percent_decoder_top
   import url_pd_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_REPORTS    = 40;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type   decoded_q [$];
   phase_type dec_phase = PH_IDLE;
   logic [7:0] pend_digit = 8'h00;

   int mismatch_count = 0;
   int idle_cycles    = 0;
   int stall_left     = 0;
   int stall_pct      = 0;
   int gap_pct        = 0;

   url_percent_decoder_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic bit hex_digit(input logic [7:0] b, output logic [3:0] nib);
      nib = 4'h0;
      if (b >= 8'h30 && b <= 8'h39) begin
         nib = 4'(b - 8'h30);
         return 1'b1;
      end
      if (b >= 8'h41 && b <= 8'h46) begin
         nib = 4'(b - 8'h37);
         return 1'b1;
      end
      if (b >= 8'h61 && b <= 8'h66) begin
         nib = 4'(b - 8'h57);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // work out the bytes one accepted transfer releases and queue them
   function automatic void predict_decode(input req_type item);
      logic [7:0] outs [$];
      logic [3:0] lo_nib;
      logic [3:0] hi_nib;
      bit         is_dig;
      bit         restart;
      rsp_type    r;
      is_dig  = hex_digit(item.in_byte, lo_nib);
      restart = 1'b0;
      case (dec_phase)
         PH_PCT: begin
            if (is_dig && !item.string_end) begin
               pend_digit = item.in_byte;
               dec_phase  = PH_DIGIT;
            end else if (is_dig) begin
               outs.push_back(PCT_CHAR);
               outs.push_back(item.in_byte);
               dec_phase = PH_IDLE;
            end else begin
               outs.push_back(PCT_CHAR);
               restart = 1'b1;
            end
         end
         PH_DIGIT: begin
            if (is_dig) begin
               void'(hex_digit(pend_digit, hi_nib));
               outs.push_back({hi_nib, lo_nib});
               dec_phase = PH_IDLE;
            end else begin
               outs.push_back(PCT_CHAR);
               outs.push_back(pend_digit);
               restart = 1'b1;
            end
         end
         default: restart = 1'b1;
      endcase
      if (restart) begin
         if (item.in_byte == PCT_CHAR && !item.string_end) begin
            dec_phase = PH_PCT;
         end else begin
            outs.push_back(item.in_byte);
            dec_phase = PH_IDLE;
         end
      end
      foreach (outs[i]) begin
         r.out_byte    = outs[i];
         r.run_last    = (i == outs.size() - 1);
         r.decoded_end = (i == outs.size() - 1) && item.string_end;
         decoded_q.push_back(r);
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            report_mismatch("unexpected transfer", 32'(rsp_data), 0);
         end else begin
            want = decoded_q.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               report_mismatch("out_byte", 32'(rsp_data.out_byte), 32'(want.out_byte));
            end
            if (rsp_data.run_last !== want.run_last) begin
               report_mismatch("run_last", 32'(rsp_data.run_last), 32'(want.run_last));
            end
            if (rsp_data.decoded_end !== want.decoded_end) begin
               report_mismatch("decoded_end", 32'(rsp_data.decoded_end),
                               32'(want.decoded_end));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver back-pressure: mostly short stalls, now and then a long one
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                   : $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // entered and left at a falling edge; valid stays high after the transfer
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < gap_pct) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_data.in_byte    <= b;
      req_data.string_end <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_decode(req_data);
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input logic end_last);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], end_last && (i == s.len() - 1));
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [7:0] rand_hex();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'(8'h30 + v);
      return $urandom_range(0, 1) ? 8'(8'h37 + v) : 8'(8'h57 + v);
   endfunction

   function automatic logic [7:0] rand_non_hex();
      logic [7:0] b;
      logic [3:0] nib;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (hex_digit(b, nib));
      return b;
   endfunction

   task automatic test_plain_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_escapes();
      send_text("%41", 1'b0);
      send_text("%fF", 1'b0);
      send_text("%00", 1'b1);
   endtask

   task automatic test_broken_sequences();
      send_text("%4z", 1'b0);
      send_text("%%41", 1'b0);
      send_text("%", 1'b1);
      send_text("%7", 1'b1);
      send_text("%b%", 1'b1);
   endtask

   task automatic test_drain_pause();
      send_text("%3a", 1'b0);
      send_text("%q", 1'b0);
      wait_drained();
      send_text("x%2", 1'b1);
      wait_drained();
   endtask

   task automatic test_random_strings(input int n_items, input int gaps, input int stalls);
      int sent;
      int kind;
      gap_pct   = gaps;
      stall_pct = stalls;
      sent      = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 99);
         if (kind < 50) begin
            send_byte(PCT_CHAR, $urandom_range(0, 11) == 0);
            send_byte(rand_hex(), $urandom_range(0, 11) == 0);
            send_byte(rand_hex(), $urandom_range(0, 9) == 0);
            sent += 3;
         end else if (kind < 70) begin
            send_byte(rand_non_hex(), $urandom_range(0, 9) == 0);
            sent += 1;
         end else if (kind < 80) begin
            send_byte(PCT_CHAR, 1'b0);
            send_byte(rand_non_hex(), $urandom_range(0, 9) == 0);
            sent += 2;
         end else if (kind < 88) begin
            send_byte(PCT_CHAR, 1'b0);
            send_byte(rand_hex(), 1'b0);
            send_byte(rand_non_hex(), $urandom_range(0, 9) == 0);
            sent += 3;
         end else begin
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            sent += 1;
         end
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_plain_bytes();
      test_escapes();
      test_broken_sequences();
      gap_pct   = 30;
      stall_pct = 30;
      test_drain_pause();
      test_random_strings(100, 0, 0);
      test_random_strings(120, 20, 20);
      wait_drained();
      test_random_strings(100, 50, 60);
      test_random_strings(80, 5, 10);

      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
